// ===== rtl/mjd_pkg.sv =====
// mjd_pkg: constants and tables for the mjd / bcd date-time decoder
// scaled-integer forms of the annex formula constants and reciprocal multipliers
// no dependencies
package mjd_pkg;

    localparam logic [15:0] MJD_FIRST_VALID = 16'd15079;

    // x100 scaling for the year estimate
    localparam logic [22:0] MJD_SCALE_Y     = 23'd100;
    localparam logic [22:0] YEAR_OFFSET_X100 = 23'd1507820;
    localparam logic [15:0] DAYS_YEAR_X100  = 16'd36525;
    localparam logic [16:0] RECIP_YEAR      = 17'd117589;

    // x10000 scaling for the month estimate
    localparam logic [29:0] MJD_SCALE_M      = 30'd10000;
    localparam logic [29:0] MONTH_OFFSET_X1E4 = 30'd149561000;
    localparam logic [18:0] DAYS_MONTH_X1E4  = 19'd306001;
    localparam logic [13:0] RECIP_MONTH      = 14'd14035;

    localparam logic [15:0] DAY_OFFSET       = 16'd14956;
    localparam logic [10:0] YEAR_BASE        = 11'd1900;

    // floor(m * 30.6001) for month estimates 0..16
    function automatic logic [8:0] month_days(input logic [4:0] mp);
        logic [8:0] res;
        case (mp)
            5'd0:    res = 9'd0;
            5'd1:    res = 9'd30;
            5'd2:    res = 9'd61;
            5'd3:    res = 9'd91;
            5'd4:    res = 9'd122;
            5'd5:    res = 9'd153;
            5'd6:    res = 9'd183;
            5'd7:    res = 9'd214;
            5'd8:    res = 9'd244;
            5'd9:    res = 9'd275;
            5'd10:   res = 9'd306;
            5'd11:   res = 9'd336;
            5'd12:   res = 9'd367;
            5'd13:   res = 9'd397;
            5'd14:   res = 9'd428;
            5'd15:   res = 9'd459;
            5'd16:   res = 9'd489;
            default: res = 9'd0;
        endcase
        return res;
    endfunction

    function automatic logic [7:0] bcd_byte(input logic [7:0] b);
        return ({4'd0, b[7:4]} * 8'd10) + {4'd0, b[3:0]};
    endfunction

endpackage

// ===== rtl/mjd_bcd_datetime_decoder.sv =====
// mjd_bcd_datetime_decoder: modified julian date to year / month / day, bcd time to binary
// eight-stage pipeline of constant-divisor arithmetic; uses mjd_pkg
// no submodules
//
// Accepts one beat per clock and returns one result beat per input beat, in order.
// A result reaches the m_ side through stage registers a to g and the output register:
// two reciprocal-multiply divisions (year and month), each with a one-step remainder
// correction, set the stage count. A stall on m_ready freezes the whole pipeline, so
// s_ready follows m_ready while the output register is full. Day numbers below 15079
// give zero date fields with m_before_range set; the time bytes are decoded regardless.
module mjd_bcd_datetime_decoder
    import mjd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_day_number,
    input  logic [23:0] s_bcd_time,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [10:0] m_year,
    output logic [3:0]  m_month,
    output logic [4:0]  m_day,
    output logic [7:0]  m_hour,
    output logic [7:0]  m_minute,
    output logic [7:0]  m_second,
    output logic        m_before_range
);

    typedef struct packed {
        logic [15:0] mjd;
        logic        flag;
        logic [7:0]  hour;
        logic [7:0]  minute;
        logic [7:0]  second;
    } side_t;

    logic en;
    logic [6:0] v_reg;
    logic       m_valid_reg;

    // stage a
    side_t       a_side_reg, a_side_next;
    logic [22:0] a_n_reg, a_n_next;
    // stage b
    side_t       b_side_reg;
    logic [22:0] b_n_reg;
    logic [7:0]  b_q0_reg, b_q0_next;
    logic [39:0] b_prod;
    // stage c
    side_t       c_side_reg;
    logic [7:0]  c_yp_reg, c_yp_next;
    logic [23:0] c_rem;
    // stage d
    side_t       d_side_reg;
    logic [7:0]  d_yp_reg;
    logic [15:0] d_d1_reg, d_d1_next;
    logic [15:0] d_ydays;
    // stage e
    side_t       e_side_reg;
    logic [7:0]  e_yp_reg;
    logic [15:0] e_d1_reg;
    logic [22:0] e_num_reg, e_num_next;
    logic [29:0] e_prod;
    // stage f
    side_t       f_side_reg;
    logic [7:0]  f_yp_reg;
    logic [15:0] f_d1_reg;
    logic [22:0] f_num_reg;
    logic [4:0]  f_mq0_reg, f_mq0_next;
    logic [36:0] f_prod;
    // stage g
    side_t       g_side_reg;
    logic [7:0]  g_yp_reg;
    logic [15:0] g_d1_reg;
    logic [4:0]  g_mp_reg, g_mp_next;
    logic [23:0] g_rem;
    // output
    logic [10:0] year_reg, year_next;
    logic [3:0]  month_reg, month_next;
    logic [4:0]  day_reg, day_next;
    logic [7:0]  hour_reg, minute_reg, second_reg;
    logic        flag_reg;
    logic        k;
    logic [16:0] dd;
    logic [5:0]  mm;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v_reg       <= {v_reg[5:0], s_valid};
            m_valid_reg <= v_reg[6];
        end
    end

    // stage a: bcd decode, range check, scaled year numerator
    always_comb begin
        a_side_next.mjd    = s_day_number;
        a_side_next.flag   = s_day_number < MJD_FIRST_VALID;
        a_side_next.hour   = bcd_byte(s_bcd_time[23:16]);
        a_side_next.minute = bcd_byte(s_bcd_time[15:8]);
        a_side_next.second = bcd_byte(s_bcd_time[7:0]);
        if (a_side_next.flag) begin
            a_n_next = '0;
        end else begin
            a_n_next = ({7'd0, s_day_number} * MJD_SCALE_Y) - YEAR_OFFSET_X100;
        end
    end

    // stage b: year quotient estimate, low by at most one
    assign b_prod    = {17'd0, a_n_reg} * {23'd0, RECIP_YEAR};
    assign b_q0_next = b_prod[39:32];

    // stage c: remainder correction
    assign c_rem     = {1'b0, b_n_reg} - ({16'd0, b_q0_reg} * {8'd0, DAYS_YEAR_X100});
    assign c_yp_next = (c_rem >= {8'd0, DAYS_YEAR_X100}) ? b_q0_reg + 8'd1 : b_q0_reg;

    // stage d: whole days in elapsed years
    assign d_ydays   = ({8'd0, c_yp_reg} * 16'd365) + {10'd0, c_yp_reg[7:2]};
    assign d_d1_next = c_side_reg.mjd - d_ydays;

    // stage e: scaled month numerator, clamped at zero
    assign e_prod = {14'd0, d_d1_reg} * MJD_SCALE_M;
    always_comb begin
        if (d_side_reg.flag || e_prod <= MONTH_OFFSET_X1E4) begin
            e_num_next = '0;
        end else begin
            e_num_next = 23'(e_prod - MONTH_OFFSET_X1E4);
        end
    end

    // stage f: month quotient estimate
    assign f_prod     = {14'd0, e_num_reg} * {23'd0, RECIP_MONTH};
    assign f_mq0_next = f_prod[36:32];

    // stage g: remainder correction
    assign g_rem     = {1'b0, f_num_reg} - ({19'd0, f_mq0_reg} * {5'd0, DAYS_MONTH_X1E4});
    assign g_mp_next = (g_rem >= {5'd0, DAYS_MONTH_X1E4}) ? f_mq0_reg + 5'd1 : f_mq0_reg;

    // output stage: day, year and month adjust
    always_comb begin
        k  = (g_mp_reg == 5'd14) || (g_mp_reg == 5'd15);
        dd = {1'b0, g_d1_reg} - {1'b0, DAY_OFFSET} - {8'd0, month_days(g_mp_reg)};
        mm = {1'b0, g_mp_reg} - 6'd1 - (k ? 6'd12 : 6'd0);
        if (g_side_reg.flag) begin
            year_next  = '0;
            month_next = '0;
            day_next   = '0;
        end else begin
            year_next  = {3'd0, g_yp_reg} + YEAR_BASE + {10'd0, k};
            month_next = mm[5] ? 4'd0 : mm[3:0];
            day_next   = dd[16] ? 5'd0 : dd[4:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_side_reg <= a_side_next;
            a_n_reg    <= a_n_next;
            b_side_reg <= a_side_reg;
            b_n_reg    <= a_n_reg;
            b_q0_reg   <= b_q0_next;
            c_side_reg <= b_side_reg;
            c_yp_reg   <= c_yp_next;
            d_side_reg <= c_side_reg;
            d_yp_reg   <= c_yp_reg;
            d_d1_reg   <= d_d1_next;
            e_side_reg <= d_side_reg;
            e_yp_reg   <= d_yp_reg;
            e_d1_reg   <= d_d1_reg;
            e_num_reg  <= e_num_next;
            f_side_reg <= e_side_reg;
            f_yp_reg   <= e_yp_reg;
            f_d1_reg   <= e_d1_reg;
            f_num_reg  <= e_num_reg;
            f_mq0_reg  <= f_mq0_next;
            g_side_reg <= f_side_reg;
            g_yp_reg   <= f_yp_reg;
            g_d1_reg   <= f_d1_reg;
            g_mp_reg   <= g_mp_next;
            year_reg   <= year_next;
            month_reg  <= month_next;
            day_reg    <= day_next;
            hour_reg   <= g_side_reg.hour;
            minute_reg <= g_side_reg.minute;
            second_reg <= g_side_reg.second;
            flag_reg   <= g_side_reg.flag;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_year         = year_reg;
    assign m_month        = month_reg;
    assign m_day          = day_reg;
    assign m_hour         = hour_reg;
    assign m_minute       = minute_reg;
    assign m_second       = second_reg;
    assign m_before_range = flag_reg;

    a_flag_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_before_range |-> m_year == 11'd0 && m_month == 4'd0 && m_day == 5'd0)
        else $error("date fields not zero for early day number");

    a_year_span: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_before_range |-> m_year >= 11'd1900 && m_year <= 11'd2038)
        else $error("year out of span");

    a_month_span: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_before_range |-> m_month >= 4'd1 && m_month <= 4'd12)
        else $error("month out of span");

    a_day_span: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_before_range |-> m_day >= 5'd1)
        else $error("day of month is zero");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(v_reg))
        else $error("pipeline moved during stall");

endmodule
